// ===== hw/rtl/rate_limited_round_robin_dispatcher_unit_defines.svh =====
// Assertion macros for the round-robin dispatcher.
// Included by the top level only; no other dependencies.
`ifndef RATE_LIMITED_ROUND_ROBIN_DISPATCHER_UNIT_DEFINES_SVH
`define RATE_LIMITED_ROUND_ROBIN_DISPATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RLRR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RLRR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`endif

// ===== hw/rtl/rlrr_pkg.sv =====
// Types and constants for the round-robin dispatcher.
// No dependencies; used by rate_limited_round_robin_dispatcher_unit.
package rlrr_pkg;

    localparam int CFG_W   = 24;
    localparam int CNT_W   = 25;
    localparam int POOL_W  = 5;
    localparam int SID_W   = 4;
    localparam int TAG_W   = 16;

    // input request kinds
    typedef enum logic [1:0] {
        MODE_MSG  = 2'd0,
        MODE_TICK = 2'd1,
        MODE_FAIL = 2'd2
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_FORWARD  = 2'd0,
        ST_OVER     = 2'd1,
        ST_RESTART  = 2'd2,
        ST_NO_SERV  = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_LOAD = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_POOL     = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_W-1:0]  RST_MAX_LOAD = 24'd1000;
    localparam logic [CFG_W-1:0]  RST_WINDOW   = 24'd1000;
    localparam logic [POOL_W-1:0] RST_POOL     = 5'd16;

    // one result request
    typedef struct packed {
        t_status              status;
        logic [SID_W-1:0]     server_index;
        logic [TAG_W-1:0]     tag;
        logic [CNT_W-1:0]     count;
    } t_result;

endpackage

// ===== hw/rtl/rate_limited_round_robin_dispatcher_unit.sv =====
// Round-robin dispatcher with a per-window rate limit (top level).
// Depends on rlrr_pkg and rate_limited_round_robin_dispatcher_unit_defines.svh.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one request per accept: a message
//   arrival, a time tick or a delivery failure report. Only messages produce a
//   result on the output channel (o_valid / i_stall): status, chosen server,
//   the message tag and the window count after that message.
//   Throughput: one request per cycle while o_stall is low; the server choice
//   is a single wraparound priority encoder over the active servers inside
//   the pool, and the window counter and tick counter update in the same cycle.
//   The output side is a result register plus one skid entry. While the skid
//   entry holds a result o_stall is high; it is driven from a register only.
//   A receiver that stalls forever thus blocks the input after two results.
//   Reset (synchronous, active low) marks all servers active, clears the
//   pointer and both counters, loads the default configuration and empties
//   the output side. Configuration is written through i_cfg_we / i_cfg_index
//   / i_cfg_data, one register per cycle; the user must write it only while
//   the block is idle; the block itself does not enforce this.
`include "rate_limited_round_robin_dispatcher_unit_defines.svh"

module rate_limited_round_robin_dispatcher_unit #(
    parameter int MAX_SERVERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [rlrr_pkg::CFG_W-1:0]  i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic [rlrr_pkg::SID_W-1:0]  i_server_id,
    input  logic [rlrr_pkg::TAG_W-1:0]  i_message_tag,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [rlrr_pkg::SID_W-1:0]  o_server_index,
    output logic [rlrr_pkg::TAG_W-1:0]  o_tag_out,
    output logic [rlrr_pkg::CNT_W-1:0]  o_window_count
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SERVERS - 1);

    // configuration registers
    logic [rlrr_pkg::CFG_W-1:0]  r_max_load;
    logic [rlrr_pkg::CFG_W-1:0]  r_window_ticks;
    logic [rlrr_pkg::POOL_W-1:0] r_pool_size;

    // dispatch state
    logic [MAX_SERVERS-1:0]      r_active, n_active;
    logic [IDX_W-1:0]            r_next_ptr, n_next_ptr;
    logic [rlrr_pkg::CNT_W-1:0]  r_msg_counter, n_msg_counter;
    logic [rlrr_pkg::CFG_W-1:0]  r_elapsed, n_elapsed;

    // output register and skid entry
    logic                        r_out_valid, r_skid_valid;
    rlrr_pkg::t_result           r_out, r_skid;

    logic                        in_fire, out_fire;
    logic                        res_valid;
    rlrr_pkg::t_result           res;
    logic [MAX_SERVERS-1:0]      pool_mask, avail, avail_hi;
    logic [IDX_W-1:0]            lo_all, lo_hi, chosen;
    logic                        expired;
    logic [rlrr_pkg::CNT_W-1:0]  cnt_inc, max_ext;

    assign in_fire  = i_valid && !o_stall;
    assign out_fire = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_load     <= rlrr_pkg::RST_MAX_LOAD;
            r_window_ticks <= rlrr_pkg::RST_WINDOW;
            r_pool_size    <= rlrr_pkg::RST_POOL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlrr_pkg::CFG_MAX_LOAD: r_max_load     <= i_cfg_data;
                rlrr_pkg::CFG_WINDOW:   r_window_ticks <= i_cfg_data;
                rlrr_pkg::CFG_POOL:     r_pool_size    <= i_cfg_data[rlrr_pkg::POOL_W-1:0];
                default: ;
            endcase
        end
    end

    // available servers: active and inside the pool (pool clamps at MAX_SERVERS)
    always_comb begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
            pool_mask[i] = (i < int'(r_pool_size));
            avail_hi[i]  = avail[i] && (i >= int'(r_next_ptr));
        end
    end
    assign avail = r_active & pool_mask;

    // wraparound priority encoder: lowest at or above pointer, else lowest overall
    always_comb begin
        lo_all = '0;
        lo_hi  = '0;
        for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
            if (avail[i])    lo_all = IDX_W'(i);
            if (avail_hi[i]) lo_hi  = IDX_W'(i);
        end
        chosen = (|avail_hi) ? lo_hi : lo_all;
    end

    // window and rate limit
    assign expired = (r_elapsed >= r_window_ticks);
    assign max_ext = {1'b0, r_max_load};
    assign cnt_inc = (r_msg_counter <= max_ext) ? (r_msg_counter + 1'b1) : r_msg_counter;

    // per-request state update and result
    always_comb begin
        n_active          = r_active;
        n_next_ptr        = r_next_ptr;
        n_msg_counter     = r_msg_counter;
        n_elapsed         = r_elapsed;
        res_valid         = 1'b0;
        res.status        = rlrr_pkg::ST_NO_SERV;
        res.server_index  = '0;
        res.tag           = i_message_tag;
        res.count         = r_msg_counter;
        if (in_fire) begin
            case (i_mode)
                rlrr_pkg::MODE_TICK: begin
                    if (r_elapsed != {rlrr_pkg::CFG_W{1'b1}}) n_elapsed = r_elapsed + 1'b1;
                end
                rlrr_pkg::MODE_FAIL: begin
                    for (int i = 0; i < MAX_SERVERS; i++) begin
                        if (i == int'(i_server_id)) n_active[i] = 1'b0;
                    end
                end
                rlrr_pkg::MODE_MSG: begin
                    res_valid = 1'b1;
                    if (avail == '0) begin
                        res.status = rlrr_pkg::ST_NO_SERV;
                    end else if (expired) begin
                        n_elapsed     = '0;
                        n_msg_counter = '0;
                        res.status    = rlrr_pkg::ST_RESTART;
                        res.count     = '0;
                    end else begin
                        n_msg_counter = cnt_inc;
                        res.count     = cnt_inc;
                        if (cnt_inc <= max_ext) begin
                            res.status       = rlrr_pkg::ST_FORWARD;
                            res.server_index = rlrr_pkg::SID_W'(chosen);
                            n_next_ptr       = (chosen == LAST_IDX) ? '0 : (chosen + 1'b1);
                        end else begin
                            res.status = rlrr_pkg::ST_OVER;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= '1;
            r_next_ptr    <= '0;
            r_msg_counter <= '0;
            r_elapsed     <= '0;
        end else begin
            r_active      <= n_active;
            r_next_ptr    <= n_next_ptr;
            r_msg_counter <= n_msg_counter;
            r_elapsed     <= n_elapsed;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_valid;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (res_valid) r_skid <= res;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_server_index = r_out.server_index;
    assign o_tag_out      = r_out.tag;
    assign o_window_count = r_out.count;

    // checks
    `RLRR_ASSERT_IMPLY(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `RLRR_ASSERT_IMPLY(a_fwd_available, i_clk, i_rst_n,
        res_valid && (res.status == rlrr_pkg::ST_FORWARD), avail[chosen])
    `RLRR_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n,
        res_valid && (res.status == rlrr_pkg::ST_RESTART),
        (r_msg_counter == '0) && (r_elapsed == '0))

endmodule

// ===== tb/rate_limited_round_robin_dispatcher_unit_tb.sv =====
// Self-checking testbench for rate_limited_round_robin_dispatcher_unit.
// Depends on rlrr_pkg; drives directed then random requests and checks every
// result against the plan's expected value or an internal dispatch predictor.
module rate_limited_round_robin_dispatcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SERVERS     = 16;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES      = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_CYCLES     = 48;

    // request kind the block ignores, register index with no register behind it
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;

    // one line of the directed plan: a register write or a request
    typedef struct packed {
        logic              is_cfg;
        logic [1:0]        cfg_idx;
        logic [23:0]       cfg_value;
        logic [1:0]        mode;
        logic [3:0]        sid;
        logic [15:0]       tag;
        logic              known;
        rlrr_pkg::t_result want;
    } t_plan_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [1:0]                    i_cfg_index;
    logic [rlrr_pkg::CFG_W-1:0]    i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [1:0]                    i_mode;
    logic [rlrr_pkg::SID_W-1:0]    i_server_id;
    logic [rlrr_pkg::TAG_W-1:0]    i_message_tag;
    logic                          o_valid;
    logic                          i_stall;
    logic [1:0]                    o_status;
    logic [rlrr_pkg::SID_W-1:0]    o_server_index;
    logic [rlrr_pkg::TAG_W-1:0]    o_tag_out;
    logic [rlrr_pkg::CNT_W-1:0]    o_window_count;

    // predictor copy of the configuration and dispatcher state
    logic [rlrr_pkg::CFG_W-1:0]    cfg_max_load;
    logic [rlrr_pkg::CFG_W-1:0]    cfg_window;
    logic [rlrr_pkg::POOL_W-1:0]   cfg_pool;
    logic [15:0]                   srv_active;
    logic [3:0]                    rr_ptr;
    logic [rlrr_pkg::CNT_W-1:0]    win_msgs;
    logic [rlrr_pkg::CFG_W-1:0]    win_ticks_seen;

    rlrr_pkg::t_result             expected_dispatch_q[$];
    t_plan_row                     plan[$];
    int                            mismatch_count;
    int                            cycle_count;
    int                            tx_idle_pct;
    int                            rx_idle_pct;
    bit                            rx_hold_req;

    rate_limited_round_robin_dispatcher_unit #(
        .MAX_SERVERS(NUM_SERVERS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_server_id    (i_server_id),
        .i_message_tag  (i_message_tag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_server_index (o_server_index),
        .o_tag_out      (o_tag_out),
        .o_window_count (o_window_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // dispatch predictor: updates state, returns 1 when a result is due
    function automatic bit predict_dispatch(input logic [1:0] mode, input logic [3:0] sid,
                                            input logic [15:0] tag,
                                            output rlrr_pkg::t_result res);
        logic [16:0] pool_span;
        logic [15:0] avail;
        logic [3:0]  idx;
        logic [3:0]  pick;
        bit          found;
        int          pool_n;
        res = '0;
        if (mode == rlrr_pkg::MODE_TICK) begin
            if (win_ticks_seen != '1) win_ticks_seen = win_ticks_seen + 1'b1;
            return 1'b0;
        end
        if (mode == rlrr_pkg::MODE_FAIL) begin
            srv_active[sid] = 1'b0;
            return 1'b0;
        end
        if (mode != rlrr_pkg::MODE_MSG) return 1'b0;

        pool_n    = (cfg_pool > NUM_SERVERS) ? NUM_SERVERS : int'(cfg_pool);
        pool_span = (17'd1 << pool_n) - 17'd1;
        avail     = srv_active & pool_span[15:0];
        pick      = '0;
        found     = 1'b0;
        if (avail == '0) begin
            res.status = rlrr_pkg::ST_NO_SERV;
        end else if (win_ticks_seen >= cfg_window) begin
            win_ticks_seen = '0;
            win_msgs       = '0;
            res.status     = rlrr_pkg::ST_RESTART;
        end else begin
            // count saturates one above the limit
            if (win_msgs <= {1'b0, cfg_max_load}) win_msgs = win_msgs + 1'b1;
            if (win_msgs <= {1'b0, cfg_max_load}) begin
                // wraparound scan upward from the round-robin pointer
                for (int k = 0; k < NUM_SERVERS; k++) begin
                    idx = rr_ptr + 4'(k);
                    if (!found && avail[idx]) begin
                        pick  = idx;
                        found = 1'b1;
                    end
                end
                rr_ptr            = pick + 1'b1;
                res.status        = rlrr_pkg::ST_FORWARD;
                res.server_index  = pick;
            end else begin
                res.status = rlrr_pkg::ST_OVER;
            end
        end
        res.tag   = tag;
        res.count = win_msgs;
        return 1'b1;
    endfunction

    function automatic t_plan_row cfg_row(input logic [1:0] idx, input logic [23:0] value);
        t_plan_row row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_idx   = idx;
        row.cfg_value = value;
        return row;
    endfunction

    function automatic t_plan_row req_row(input logic [1:0] mode, input logic [3:0] sid,
                                          input logic [15:0] tag);
        t_plan_row row;
        row      = '0;
        row.mode = mode;
        row.sid  = sid;
        row.tag  = tag;
        return row;
    endfunction

    function automatic t_plan_row known_row(input logic [3:0] sid, input logic [15:0] tag,
                                            input rlrr_pkg::t_status st,
                                            input logic [3:0] srv,
                                            input logic [24:0] cnt);
        t_plan_row row;
        row                   = req_row(rlrr_pkg::MODE_MSG, sid, tag);
        row.known             = 1'b1;
        row.want.status       = st;
        row.want.server_index = srv;
        row.want.tag          = tag;
        row.want.count        = cnt;
        return row;
    endfunction

    // append one line to the directed plan
    function automatic void add_row(input t_plan_row row);
        plan.insert(plan.size(), row);
    endfunction

    // offer one request, optionally after an idle gap; returns once accepted
    task automatic offer_request(input logic [1:0] mode, input logic [3:0] sid,
                                 input logic [15:0] tag, input bit known,
                                 input rlrr_pkg::t_result want);
        rlrr_pkg::t_result res;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_server_id   <= sid;
        i_message_tag <= tag;
        do @(posedge i_clk); while (o_stall);
        if (predict_dispatch(mode, sid, tag, res))
            expected_dispatch_q.insert(expected_dispatch_q.size(), known ? want : res);
    endtask

    // register write once the block has gone quiet
    task automatic write_cfg_reg(input logic [1:0] idx, input logic [23:0] value);
        i_valid <= 1'b0;
        while (expected_dispatch_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rlrr_pkg::CFG_MAX_LOAD: cfg_max_load = value;
            rlrr_pkg::CFG_WINDOW:   cfg_window   = value;
            rlrr_pkg::CFG_POOL:     cfg_pool     = value[rlrr_pkg::POOL_W-1:0];
            default: ;
        endcase
    endtask

    // result side: random stall, one long hold-off on request, field checks
    initial begin
        rlrr_pkg::t_result want;
        int                hold_left;
        hold_left      = 0;
        mismatch_count = 0;
        i_stall        <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_dispatch_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: exp none, got st %0d srv %0d tag %h cnt %0d",
                             $time, o_status, o_server_index, o_tag_out, o_window_count);
                end else begin
                    want = expected_dispatch_q.pop_front();
                    if (o_status !== want.status || o_server_index !== want.server_index ||
                        o_tag_out !== want.tag || o_window_count !== want.count) begin
                        mismatch_count++;
                        $display("%0t: mismatch exp st %0d srv %0d tag %h cnt %0d, %s",
                                 $time, want.status, want.server_index, want.tag,
                                 want.count,
                                 $sformatf("got st %0d srv %0d tag %h cnt %0d",
                                           o_status, o_server_index, o_tag_out,
                                           o_window_count));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                i_stall     <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial begin
        t_plan_row   row;
        logic [1:0]  mode;
        logic [3:0]  sid;
        logic [15:0] tag;
        logic [23:0] ph_load;
        logic [23:0] ph_window;
        logic [23:0] ph_pool;
        int          sent;
        int          pick;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_mode        <= rlrr_pkg::MODE_MSG;
        i_server_id   <= '0;
        i_message_tag <= '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_req    = 1'b0;

        cfg_max_load   = rlrr_pkg::RST_MAX_LOAD;
        cfg_window     = rlrr_pkg::RST_WINDOW;
        cfg_pool       = rlrr_pkg::RST_POOL;
        srv_active     = '1;
        rr_ptr         = '0;
        win_msgs       = '0;
        win_ticks_seen = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan: reset defaults, skipping a failed server, window
        // restart, over limit, zero window, empty and oversized pool
        add_row(known_row(4'h0, 16'h0000, rlrr_pkg::ST_FORWARD, 4'd0, 25'd1));
        add_row(known_row(4'hF, 16'hFFFF, rlrr_pkg::ST_FORWARD, 4'd1, 25'd2));
        add_row(req_row(rlrr_pkg::MODE_FAIL, 4'd2, 16'h0000));
        add_row(known_row(4'h0, 16'h1234, rlrr_pkg::ST_FORWARD, 4'd3, 25'd3));
        add_row(req_row(rlrr_pkg::MODE_TICK, 4'hF, 16'hFFFF));
        add_row(req_row(MODE_IGNORED, 4'hF, 16'hFFFF));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'h5, 16'hA5A5));
        add_row(cfg_row(rlrr_pkg::CFG_WINDOW, 24'd1));
        add_row(known_row(4'hA, 16'h5A5A, rlrr_pkg::ST_RESTART, 4'd0, 25'd0));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'h1, 16'h0001));
        add_row(cfg_row(rlrr_pkg::CFG_MAX_LOAD, 24'd0));
        add_row(known_row(4'h8, 16'h8000, rlrr_pkg::ST_OVER, 4'd0, 25'd1));
        add_row(cfg_row(rlrr_pkg::CFG_MAX_LOAD, 24'hFFFFFF));
        add_row(cfg_row(rlrr_pkg::CFG_WINDOW, 24'd0));
        add_row(known_row(4'h7, 16'h7FFF, rlrr_pkg::ST_RESTART, 4'd0, 25'd0));
        add_row(cfg_row(rlrr_pkg::CFG_WINDOW, 24'hFFFFFF));
        add_row(cfg_row(CFG_UNUSED, 24'hFFFFFF));
        add_row(cfg_row(rlrr_pkg::CFG_POOL, 24'd0));
        add_row(known_row(4'h3, 16'h00FF, rlrr_pkg::ST_NO_SERV, 4'd0, 25'd0));
        add_row(cfg_row(rlrr_pkg::CFG_POOL, 24'hFFFFFF));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'hC, 16'hFF00));
        add_row(cfg_row(rlrr_pkg::CFG_POOL, 24'd1));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'h0, 16'h0F0F));
        add_row(req_row(rlrr_pkg::MODE_FAIL, 4'd0, 16'hFFFF));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'h6, 16'hF0F0));
        add_row(req_row(rlrr_pkg::MODE_FAIL, 4'd15, 16'h0000));
        add_row(cfg_row(rlrr_pkg::CFG_POOL, 24'd16));
        add_row(req_row(rlrr_pkg::MODE_TICK, 4'h9, 16'h3C3C));
        add_row(req_row(rlrr_pkg::MODE_MSG, 4'h9, 16'h3C3C));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg)
                write_cfg_reg(row.cfg_idx, row.cfg_value);
            else
                offer_request(row.mode, row.sid, row.tag, row.known, row.want);
        end

        // random phases, each with its own configuration; pairs of phases share an idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin ph_load = 24'd5;      ph_window = 24'd8;      ph_pool = 24'd16; end
                1: begin ph_load = 24'd0;      ph_window = 24'd3;      ph_pool = 24'd4;  end
                2: begin ph_load = 24'hFFFFFF; ph_window = 24'hFFFFFF; ph_pool = 24'd31; end
                3: begin ph_load = 24'd2;      ph_window = 24'd1;      ph_pool = 24'd9;  end
                4: begin ph_load = 24'd12;     ph_window = 24'd20;     ph_pool = 24'd16; end
                default: begin ph_load = 24'd3; ph_window = 24'd6;     ph_pool = 24'd4;  end
            endcase
            write_cfg_reg(rlrr_pkg::CFG_MAX_LOAD, ph_load);
            write_cfg_reg(rlrr_pkg::CFG_WINDOW, ph_window);
            write_cfg_reg(rlrr_pkg::CFG_POOL, ph_pool);
            if (ph < 2) begin
                tx_idle_pct = 29;
                rx_idle_pct = 66;
            end else if (ph < 4) begin
                tx_idle_pct = 66;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver hold-off so the block backs up into its input
            if (ph == 4) rx_hold_req = 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                sid  = 4'($urandom_range(0, 15));
                tag  = 16'($urandom_range(0, 65535));
                if (pick < 58)      mode = rlrr_pkg::MODE_MSG;
                else if (pick < 88) mode = rlrr_pkg::MODE_TICK;
                else if (pick < 95) mode = rlrr_pkg::MODE_FAIL;
                else                mode = MODE_IGNORED;
                // servers never come back, so keep a few alive until the last phase
                if (mode == rlrr_pkg::MODE_FAIL && ph < NUM_PHASES - 1 && srv_active[sid] &&
                    $countones(srv_active) <= 6)
                    mode = rlrr_pkg::MODE_TICK;
                offer_request(mode, sid, tag, 1'b0, '0);
                if (mode != MODE_IGNORED) sent++;
            end
        end

        // drain, then allow for any stray result
        i_valid <= 1'b0;
        while (expected_dispatch_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rlrr_pkg.sv
hw/rtl/rate_limited_round_robin_dispatcher_unit.sv
tb/rate_limited_round_robin_dispatcher_unit_tb.sv
